### design/rtb_pkg.sv
// Shared types, constants and helpers of the RGBA tone and blend pipeline.
package rtb_pkg;

    // Pipeline stage indexes
    localparam int NSTG  = 6;
    localparam int STG_A = 0;   // luma and beta products
    localparam int STG_B = 1;   // luma sum, beta
    localparam int STG_C = 2;   // saturation products
    localparam int STG_D = 3;   // saturated color, tone products
    localparam int STG_E = 4;   // toned color, blend products
    localparam int STG_F = 5;   // blended result (output register)

    // Blend mode codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_ALPHA = 3'd1;
    localparam logic [2:0] MODE_ADD   = 3'd2;
    localparam logic [2:0] MODE_SUB   = 3'd3;
    localparam logic [2:0] MODE_MASK  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_GLOBAL_ALPHA = 3'd0;
    localparam logic [2:0] CFG_BLEND_MODE   = 3'd1;
    localparam logic [2:0] CFG_SATURATION   = 3'd2;
    localparam logic [2:0] CFG_TONE_RED     = 3'd3;
    localparam logic [2:0] CFG_TONE_GREEN   = 3'd4;
    localparam logic [2:0] CFG_TONE_BLUE    = 3'd5;

    // Luma weights, sum of the products scaled by 2^15
    localparam logic [14:0] LUMA_R = 15'd6969;
    localparam logic [14:0] LUMA_G = 15'd23434;
    localparam logic [14:0] LUMA_B = 15'd2365;

    localparam logic [7:0] FULL = 8'd255;

    typedef struct packed {
        logic [7:0] source_red;
        logic [7:0] source_green;
        logic [7:0] source_blue;
        logic [7:0] source_opacity;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
        logic [7:0] target_opacity;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] result_red;
        logic [7:0] result_green;
        logic [7:0] result_blue;
        logic [7:0] result_opacity;
        logic       mode_unsupported;
    } t_pix_out;

    typedef struct packed {
        logic [7:0]        global_alpha;
        logic [2:0]        blend_mode;
        logic [7:0]        saturation_level;
        logic signed [8:0] tone_red;
        logic signed [8:0] tone_green;
        logic signed [8:0] tone_blue;
    } t_cfg;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_ctl;

    // Color path contents at the end of stage D
    typedef struct packed {
        logic [2:0][15:0] tone_prod;
        logic [2:0]       tone_zero;
        logic [2:0][7:0]  sat_col;
        logic [7:0]       beta;
        t_pix_in          pix;
    } t_col;

    // (x + 255) >> 8, x at most 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'd255;
        return sum[15:8];
    endfunction

endpackage

### design/rtb_ctl.sv
// Valid tracking and per-stage load enables of the pixel pipeline.
module rtb_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rtb_pkg::t_pipe_ctl o_ctl
);
    import rtb_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en    = en;
    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

endmodule

### design/rtb_color.sv
// Color path stages A to D: luma, beta, saturation and tone products.
module rtb_color (
    input  logic               i_clk,
    input  rtb_pkg::t_cfg      i_cfg,
    input  rtb_pkg::t_pipe_ctl i_ctl,
    input  rtb_pkg::t_pix_in   i_pix,
    output rtb_pkg::t_col      o_col
);
    import rtb_pkg::*;

    // Stage A
    t_pix_in     r_a_pix;
    logic [22:0] r_a_luma [3];
    logic [15:0] r_a_bprod;
    // Stage B
    t_pix_in     r_b_pix;
    logic [7:0]  r_b_y;
    logic [7:0]  r_b_beta;
    // Stage C
    t_pix_in     r_c_pix;
    logic [15:0] r_c_sprod [3];
    logic [7:0]  r_c_beta;
    // Stage D
    t_col        r_d;

    logic [7:0]        a_src  [3];
    logic [14:0]       coef   [3];
    logic [7:0]        b_src  [3];
    logic [7:0]        c_src  [3];
    logic signed [8:0] tone   [3];
    logic [23:0]       luma_sum;
    t_col              n_d;

    assign a_src = '{i_pix.source_red, i_pix.source_green, i_pix.source_blue};
    assign coef  = '{LUMA_R, LUMA_G, LUMA_B};
    assign b_src = '{r_b_pix.source_red, r_b_pix.source_green, r_b_pix.source_blue};
    assign c_src = '{r_c_pix.source_red, r_c_pix.source_green, r_c_pix.source_blue};
    assign tone  = '{i_cfg.tone_red, i_cfg.tone_green, i_cfg.tone_blue};

    // Stage A: weighted channels and source alpha times global alpha
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_A]) begin
            r_a_pix   <= i_pix;
            for (int i = 0; i < 3; i++) begin
                r_a_luma[i] <= 23'(coef[i]) * 23'(a_src[i]);
            end
            r_a_bprod <= 16'(i_pix.source_opacity) * 16'(i_cfg.global_alpha);
        end
    end

    // Stage B: luma and beta; the luma sum stays below 2^23
    assign luma_sum = 24'(r_a_luma[0]) + 24'(r_a_luma[1]) + 24'(r_a_luma[2]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_B]) begin
            r_b_pix  <= r_a_pix;
            r_b_y    <= luma_sum[22:15];
            r_b_beta <= div255(r_a_bprod);
        end
    end

    // Stage C: mix of each channel toward luma
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_C]) begin
            r_c_pix  <= r_b_pix;
            r_c_beta <= r_b_beta;
            for (int i = 0; i < 3; i++) begin
                r_c_sprod[i] <= 16'(b_src[i]) * 16'(i_cfg.saturation_level)
                              + 16'(r_b_y) * 16'(FULL - i_cfg.saturation_level);
            end
        end
    end

    // Stage D: saturated color and tone products
    always_comb begin
        logic [7:0] sat;
        logic [8:0] neg_t;
        logic [7:0] mag;
        logic       pos;
        n_d      = r_d;
        n_d.pix  = r_c_pix;
        n_d.beta = r_c_beta;
        for (int i = 0; i < 3; i++) begin
            sat   = (i_cfg.saturation_level != FULL) ? div255(r_c_sprod[i]) : c_src[i];
            neg_t = 9'(-tone[i]);
            pos   = ~tone[i][8];
            // a tone of -256 saturates to 255
            if (pos) begin
                mag = tone[i][7:0];
            end else begin
                mag = neg_t[8] ? FULL : neg_t[7:0];
            end
            n_d.sat_col[i]   = sat;
            n_d.tone_zero[i] = (tone[i] == 9'sd0);
            n_d.tone_prod[i] = 16'(sat) * 16'(FULL - mag)
                             + (pos ? 16'(mag) * 16'(FULL) : 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_D]) begin
            r_d <= n_d;
        end
    end

    assign o_col = r_d;

endmodule

### design/rtb_blend.sv
// Blend stages E and F: toned source, blend products and mode select.
module rtb_blend (
    input  logic               i_clk,
    input  rtb_pkg::t_cfg      i_cfg,
    input  rtb_pkg::t_pipe_ctl i_ctl,
    input  rtb_pkg::t_col      i_col,
    output rtb_pkg::t_pix_out  o_pix
);
    import rtb_pkg::*;

    // Stage E
    t_pix_in     r_e_pix;
    logic [7:0]  r_e_beta;
    logic [7:0]  r_e_s    [3];
    logic [15:0] r_e_pa   [3];
    logic [15:0] r_e_pb   [3];
    // Stage F
    t_pix_out    r_f;

    logic [7:0] e_dst [3];
    logic [7:0] f_dst [3];
    logic [7:0] e_s   [3];
    logic [7:0] res   [3];
    t_pix_out   n_f;

    assign e_dst = '{i_col.pix.target_red, i_col.pix.target_green, i_col.pix.target_blue};
    assign f_dst = '{r_e_pix.target_red, r_e_pix.target_green, r_e_pix.target_blue};

    // Stage E: finish tone, form source*beta and dest*(255-beta)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_s[i] = i_col.tone_zero[i] ? i_col.sat_col[i] : div255(i_col.tone_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_E]) begin
            r_e_pix  <= i_col.pix;
            r_e_beta <= i_col.beta;
            for (int i = 0; i < 3; i++) begin
                r_e_s[i]  <= e_s[i];
                r_e_pa[i] <= 16'(e_s[i]) * 16'(i_col.beta);
                r_e_pb[i] <= 16'(e_dst[i]) * 16'(FULL - i_col.beta);
            end
        end
    end

    // Stage F: blend by mode
    always_comb begin
        logic [8:0] sum;
        logic [7:0] v;
        logic       empty;
        empty = (r_e_pix.target_opacity == 8'd0);
        for (int i = 0; i < 3; i++) begin
            v   = empty ? r_e_s[i] : div255(r_e_pa[i]);
            sum = 9'(v) + 9'(f_dst[i]);
            case (i_cfg.blend_mode)
                MODE_NONE:  res[i] = r_e_s[i];
                MODE_ALPHA: res[i] = empty ? r_e_s[i] : div255(r_e_pa[i] + r_e_pb[i]);
                MODE_ADD:   res[i] = sum[8] ? FULL : sum[7:0];
                MODE_SUB:   res[i] = (f_dst[i] > v) ? f_dst[i] - v : 8'd0;
                default:    res[i] = f_dst[i];
            endcase
        end
        n_f.result_red       = res[0];
        n_f.result_green     = res[1];
        n_f.result_blue      = res[2];
        n_f.mode_unsupported = 1'b0;
        case (i_cfg.blend_mode)
            MODE_NONE: begin
                n_f.result_opacity = r_e_pix.source_opacity;
            end
            MODE_ALPHA, MODE_ADD, MODE_SUB: begin
                if (empty || r_e_pix.target_opacity < r_e_beta) begin
                    n_f.result_opacity = r_e_beta;
                end else begin
                    n_f.result_opacity = r_e_pix.target_opacity;
                end
            end
            MODE_MASK: begin
                n_f.result_opacity = r_e_pix.source_red;
            end
            default: begin
                // multiply and undefined codes pass the destination through
                n_f.result_opacity   = r_e_pix.target_opacity;
                n_f.mode_unsupported = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_F]) begin
            r_f <= n_f;
        end
    end

    assign o_pix = r_f;

endmodule

### design/rgba_tone_and_blend_top.sv
// Top level of the RGBA tone, saturation and blend pipeline.
//
//  channel  | valid       | ready        | payload
//  ---------+-------------+--------------+-----------------------------------
//  pixel in | i_in_valid  | o_in_ready   | i_in_data  (source and target RGBA)
//  pixel out| o_out_valid | i_out_ready  | o_out_data (result RGBA, flag)
//  config   | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Six register stages; a pixel passes through stages A to E into the output
// register F, from which its result can transfer out, and one pixel per cycle
// flows through at full rate while the output does not stall.
// Each stage loads when empty or when its content moves on, so bubbles close
// up while the output stalls and no pixel is lost or repeated.
// Reset empties the pipeline and loads the configuration defaults.
// Config writes complete in the cycle they are presented.
module rgba_tone_and_blend_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rtb_pkg::t_pix_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rtb_pkg::t_pix_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data
);
    import rtb_pkg::*;

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_pipe_ctl ctl;
    t_col      col;

    // Configuration register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GLOBAL_ALPHA: n_cfg.global_alpha     = i_cfg_data[7:0];
                CFG_BLEND_MODE:   n_cfg.blend_mode       = i_cfg_data[2:0];
                CFG_SATURATION:   n_cfg.saturation_level = i_cfg_data[7:0];
                CFG_TONE_RED:     n_cfg.tone_red         = i_cfg_data;
                CFG_TONE_GREEN:   n_cfg.tone_green       = i_cfg_data;
                CFG_TONE_BLUE:    n_cfg.tone_blue        = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.global_alpha     <= 8'd255;
            r_cfg.blend_mode       <= MODE_ALPHA;
            r_cfg.saturation_level <= 8'd255;
            r_cfg.tone_red         <= 9'sd0;
            r_cfg.tone_green       <= 9'sd0;
            r_cfg.tone_blue        <= 9'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;

    rtb_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    rtb_color u_color (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .i_ctl (ctl),
        .i_pix (i_in_data),
        .o_col (col)
    );

    rtb_blend u_blend (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .i_ctl (ctl),
        .i_col (col),
        .o_pix (o_out_data)
    );

endmodule

### test/rgba_tone_and_blend_top_tb.sv
// Self-checking testbench for the RGBA tone, saturation and blend pipeline.
module rgba_tone_and_blend_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtb_pkg::*;

    localparam int         CLK_HALF      = 5;
    localparam int         RESET_CYCLES  = 4;
    localparam int         RANDOM_PIXELS = 1330;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         MAX_REPORTS   = 10;

    // Codes the package does not name
    localparam logic [2:0] MODE_MULTIPLY = 3'd5;
    localparam logic [2:0] MODE_UNDEF_6  = 3'd6;
    localparam logic [2:0] MODE_UNDEF_7  = 3'd7;
    localparam logic [2:0] CFG_UNUSED_6  = 3'd6;
    localparam logic [2:0] CFG_UNUSED_7  = 3'd7;

    // Tone extremes: full up, full down, and the code whose magnitude saturates
    localparam logic [8:0] TONE_UP_MAX    = 9'h0FF;
    localparam logic [8:0] TONE_DOWN_MAX  = 9'h101;
    localparam logic [8:0] TONE_DOWN_WRAP = 9'h100;

    // One entry of the directed sequence: a register write or a pixel
    typedef struct {
        bit         is_write;
        logic [2:0] reg_index;
        logic [8:0] reg_value;
        t_pix_in    pixel;
        bit         typed;
        t_pix_out   want;
    } t_step;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_pix_in    i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_pix_out   o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    // Register copies used for prediction
    logic [7:0]        ga_reg   = FULL;
    logic [2:0]        mode_reg = MODE_ALPHA;
    logic [7:0]        sat_reg  = FULL;
    logic signed [8:0] tone_reg [3] = '{9'sd0, 9'sd0, 9'sd0};

    t_pix_out pending_results [$];
    t_pix_out next_result;
    t_step    plan [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       pixels_sent    = 0;
    int       stall_left     = 0;
    bit       full_rate      = 1'b0;

    rgba_tone_and_blend_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic int round255(int x);
        return (x + 255) >> 8;
    endfunction

    function automatic int mix255(int s, int d, int a);
        return round255(s * a + d * (255 - a));
    endfunction

    // Positive tone pulls toward white, negative toward black
    function automatic int shade(int c, int t);
        int m;
        if (t == 0) return c;
        m = (t > 0) ? t : -t;
        if (m > 255) m = 255;
        return (t > 0) ? mix255(255, c, m) : mix255(0, c, m);
    endfunction

    function automatic t_pix_out predict_pixel(t_pix_in p);
        int       src [3];
        int       dst [3];
        int       dst_alpha;
        int       beta;
        int       luma;
        int       scaled;
        int       i;
        t_pix_out r;
        src[0]    = p.source_red;
        src[1]    = p.source_green;
        src[2]    = p.source_blue;
        dst[0]    = p.target_red;
        dst[1]    = p.target_green;
        dst[2]    = p.target_blue;
        dst_alpha = p.target_opacity;
        r.mode_unsupported = 1'b0;
        if (mode_reg == MODE_MASK) begin
            // color kept, opacity taken from source red
            dst_alpha = src[0];
        end else if (mode_reg > MODE_MASK) begin
            // multiply and undefined codes pass the destination through
            r.mode_unsupported = 1'b1;
        end else begin
            if (sat_reg != FULL) begin
                luma = (int'(LUMA_R) * src[0] + int'(LUMA_G) * src[1]
                        + int'(LUMA_B) * src[2]) >> 15;
                for (i = 0; i < 3; i++) src[i] = mix255(src[i], luma, int'(sat_reg));
            end
            for (i = 0; i < 3; i++) src[i] = shade(src[i], int'(tone_reg[i]));
            beta = round255(int'(p.source_opacity) * int'(ga_reg));
            if (mode_reg == MODE_NONE) begin
                for (i = 0; i < 3; i++) dst[i] = src[i];
                dst_alpha = p.source_opacity;
            end else if (dst_alpha == 0) begin
                // empty destination: source color taken without weighting
                for (i = 0; i < 3; i++) begin
                    case (mode_reg)
                        MODE_ALPHA: dst[i] = src[i];
                        MODE_ADD:   dst[i] = (src[i] + dst[i] > 255) ? 255 : src[i] + dst[i];
                        default:    dst[i] = (dst[i] > src[i]) ? dst[i] - src[i] : 0;
                    endcase
                end
                dst_alpha = beta;
            end else begin
                if (dst_alpha < beta) dst_alpha = beta;
                for (i = 0; i < 3; i++) begin
                    scaled = round255(src[i] * beta);
                    case (mode_reg)
                        MODE_ALPHA: dst[i] = mix255(src[i], dst[i], beta);
                        MODE_ADD:   dst[i] = (scaled + dst[i] > 255) ? 255 : scaled + dst[i];
                        default:    dst[i] = (dst[i] > scaled) ? dst[i] - scaled : 0;
                    endcase
                end
            end
        end
        r.result_red     = 8'(dst[0]);
        r.result_green   = 8'(dst[1]);
        r.result_blue    = 8'(dst[2]);
        r.result_opacity = 8'(dst_alpha);
        return r;
    endfunction

    function automatic void note_reg_write(logic [2:0] idx, logic [8:0] val);
        case (idx)
            CFG_GLOBAL_ALPHA: ga_reg      = val[7:0];
            CFG_BLEND_MODE:   mode_reg    = val[2:0];
            CFG_SATURATION:   sat_reg     = val[7:0];
            CFG_TONE_RED:     tone_reg[0] = val;
            CFG_TONE_GREEN:   tone_reg[1] = val;
            CFG_TONE_BLUE:    tone_reg[2] = val;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_pix_in rgba_pair(int sr, int sg, int sb, int sa,
                                          int tr, int tg, int tb, int ta);
        return {8'(sr), 8'(sg), 8'(sb), 8'(sa), 8'(tr), 8'(tg), 8'(tb), 8'(ta)};
    endfunction

    function automatic t_pix_out rgba_result(int r, int g, int b, int a, bit unsup);
        return {8'(r), 8'(g), 8'(b), 8'(a), unsup};
    endfunction

    function automatic t_step write_step(logic [2:0] idx, logic [8:0] val);
        t_step s;
        s.is_write  = 1'b1;
        s.reg_index = idx;
        s.reg_value = val;
        s.pixel     = '0;
        s.typed     = 1'b0;
        s.want      = '0;
        return s;
    endfunction

    function automatic t_step pixel_step(t_pix_in p, bit typed, t_pix_out want);
        t_step s;
        s.is_write  = 1'b0;
        s.reg_index = '0;
        s.reg_value = '0;
        s.pixel     = p;
        s.typed     = typed;
        s.want      = want;
        return s;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (full_rate) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [8:0] pick_tone();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return 9'h000;
        if (roll < 40) return TONE_UP_MAX;
        if (roll < 50) return TONE_DOWN_MAX;
        if (roll < 55) return TONE_DOWN_WRAP;
        return 9'($urandom);
    endfunction

    // 8-bit level; bit 8 is ignored by the block and toggled anyway
    function automatic logic [8:0] pick_level(int full_pct);
        int         roll;
        logic [7:0] lvl;
        roll = $urandom_range(99);
        if (roll < full_pct) lvl = FULL;
        else if (roll < full_pct + 10) lvl = 8'd0;
        else lvl = 8'($urandom);
        return {1'($urandom), lvl};
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        int      roll;
        p    = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 20) p.target_opacity = 8'd0;
        else if (roll < 30) p.target_opacity = FULL;
        roll = $urandom_range(99);
        if (roll < 15) p.source_opacity = 8'd0;
        else if (roll < 30) p.source_opacity = FULL;
        if ($urandom_range(9) == 0) p.source_red = FULL;
        if ($urandom_range(9) == 0) p.source_green = 8'd0;
        return p;
    endfunction

    // Present one pixel and hold it until the transfer
    task automatic send_pixel(t_pix_in p, bit typed, t_pix_out want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(typed ? want : predict_pixel(p));
    endtask

    // Stop sending and wait for every pending result
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        note_reg_write(idx, val);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [8:0] ga, logic [8:0] mode, logic [8:0] sat,
                                  logic [8:0] tr, logic [8:0] tg, logic [8:0] tb);
        write_reg(CFG_GLOBAL_ALPHA, ga);
        write_reg(CFG_BLEND_MODE, mode);
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_TONE_RED, tr);
        write_reg(CFG_TONE_GREEN, tg);
        write_reg(CFG_TONE_BLUE, tb);
    endtask

    task automatic log_mismatch(string what, t_pix_out want, t_pix_out got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected rgba %0d %0d %0d %0d unsup %0d, got %0d %0d %0d %0d unsup %0d",
                     $time, what, want.result_red, want.result_green, want.result_blue,
                     want.result_opacity, want.mode_unsupported, got.result_red,
                     got.result_green, got.result_blue, got.result_opacity,
                     got.mode_unsupported);
    endtask

    // ---------------------------------------------------------------- output side

    // Check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result with nothing pending", '0, o_out_data);
            end else begin
                next_result = pending_results.pop_front();
                if (o_out_data.result_red       !== next_result.result_red   ||
                    o_out_data.result_green     !== next_result.result_green ||
                    o_out_data.result_blue      !== next_result.result_blue  ||
                    o_out_data.result_opacity   !== next_result.result_opacity ||
                    o_out_data.mode_unsupported !== next_result.mode_unsupported)
                    log_mismatch("wrong result", next_result, o_out_data);
            end
        end
        if (full_rate) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            i_out_ready <= (stall_left == 0);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rgba_tone_and_blend_top regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_pix_in p;
        int      phase;
        int      burst;
        int      mode_roll;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GLOBAL_ALPHA;
        i_cfg_data  <= '0;

        // Reset settings: alpha blend, full opacity, full color, no tone
        // empty destination takes the source and beta
        plan.push_back(pixel_step(rgba_pair(10, 20, 30, 255, 1, 2, 3, 0), 1,
                                  rgba_result(10, 20, 30, 255, 0)));
        // transparent source leaves the destination
        plan.push_back(pixel_step(rgba_pair(200, 100, 50, 0, 40, 50, 60, 77), 1,
                                  rgba_result(40, 50, 60, 77, 0)));
        // opaque source replaces it
        plan.push_back(pixel_step(rgba_pair(255, 0, 128, 255, 7, 8, 9, 200), 1,
                                  rgba_result(255, 0, 128, 255, 0)));
        plan.push_back(pixel_step(rgba_pair(0, 255, 255, 128, 255, 0, 77, 1), 0, '0));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_NONE)));
        plan.push_back(pixel_step(rgba_pair(1, 2, 3, 4, 9, 9, 9, 9), 1,
                                  rgba_result(1, 2, 3, 4, 0)));
        // mask: destination color, opacity from source red
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_MASK)));
        plan.push_back(pixel_step(rgba_pair(123, 0, 0, 0, 11, 22, 33, 44), 1,
                                  rgba_result(11, 22, 33, 123, 0)));
        plan.push_back(pixel_step(rgba_pair(0, 255, 255, 255, 255, 255, 255, 0), 1,
                                  rgba_result(255, 255, 255, 0, 0)));
        // multiply and the undefined codes pass through with the flag
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_MULTIPLY)));
        plan.push_back(pixel_step(rgba_pair(50, 60, 70, 80, 90, 100, 110, 120), 1,
                                  rgba_result(90, 100, 110, 120, 1)));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_UNDEF_6)));
        plan.push_back(pixel_step(rgba_pair(255, 255, 255, 255, 0, 0, 0, 0), 1,
                                  rgba_result(0, 0, 0, 0, 1)));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_UNDEF_7)));
        plan.push_back(pixel_step(rgba_pair(0, 0, 0, 0, 255, 255, 255, 255), 1,
                                  rgba_result(255, 255, 255, 255, 1)));
        // add and subtract, empty and occupied destination
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_ADD)));
        plan.push_back(pixel_step(rgba_pair(200, 100, 0, 255, 100, 0, 255, 0), 1,
                                  rgba_result(255, 100, 255, 255, 0)));
        plan.push_back(pixel_step(rgba_pair(200, 100, 0, 128, 100, 0, 255, 50), 0, '0));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_SUB)));
        plan.push_back(pixel_step(rgba_pair(100, 10, 0, 255, 50, 10, 255, 0), 1,
                                  rgba_result(0, 0, 255, 255, 0)));
        plan.push_back(pixel_step(rgba_pair(90, 200, 255, 170, 100, 150, 3, 90), 0, '0));
        // zero global opacity: beta is zero
        plan.push_back(write_step(CFG_GLOBAL_ALPHA, 9'd0));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_ALPHA)));
        plan.push_back(pixel_step(rgba_pair(10, 20, 30, 255, 40, 50, 60, 70), 1,
                                  rgba_result(40, 50, 60, 70, 0)));
        // zero saturation gives plain luma
        plan.push_back(write_step(CFG_GLOBAL_ALPHA, 9'(FULL)));
        plan.push_back(write_step(CFG_SATURATION, 9'd0));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_NONE)));
        plan.push_back(pixel_step(rgba_pair(255, 0, 0, 9, 0, 0, 0, 0), 1,
                                  rgba_result(54, 54, 54, 9, 0)));
        plan.push_back(pixel_step(rgba_pair(77, 77, 77, 200, 5, 6, 7, 8), 1,
                                  rgba_result(77, 77, 77, 200, 0)));
        plan.push_back(pixel_step(rgba_pair(12, 200, 99, 50, 1, 1, 1, 1), 0, '0));
        // tone extremes, the most negative code saturating to full
        plan.push_back(write_step(CFG_SATURATION, 9'(FULL)));
        plan.push_back(write_step(CFG_TONE_RED, TONE_UP_MAX));
        plan.push_back(write_step(CFG_TONE_GREEN, TONE_DOWN_MAX));
        plan.push_back(write_step(CFG_TONE_BLUE, TONE_DOWN_WRAP));
        plan.push_back(pixel_step(rgba_pair(0, 255, 128, 255, 3, 3, 3, 3), 1,
                                  rgba_result(255, 0, 0, 255, 0)));
        // mid-range everything
        plan.push_back(write_step(CFG_TONE_RED, 9'd100));
        plan.push_back(write_step(CFG_TONE_GREEN, 9'h1DB));
        plan.push_back(write_step(CFG_TONE_BLUE, 9'd1));
        plan.push_back(write_step(CFG_SATURATION, 9'd128));
        plan.push_back(write_step(CFG_BLEND_MODE, 9'(MODE_ALPHA)));
        plan.push_back(pixel_step(rgba_pair(30, 140, 250, 200, 60, 70, 80, 150), 0, '0));
        plan.push_back(pixel_step(rgba_pair(255, 255, 0, 77, 0, 128, 255, 255), 0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                wait_idle();
                write_reg(plan[k].reg_index, plan[k].reg_value);
            end else begin
                send_pixel(plan[k].pixel, plan[k].typed, plan[k].want);
            end
        end

        // Random part, one register setting per phase
        phase = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            wait_idle();
            full_rate = 1'b0;
            case (phase)
                0: apply_settings(9'd0, 9'(MODE_ALPHA), 9'd0,
                                  TONE_DOWN_WRAP, TONE_UP_MAX, TONE_DOWN_MAX);
                1: apply_settings(9'h1FF, 9'(MODE_SUB), 9'h1FF,
                                  TONE_UP_MAX, TONE_UP_MAX, TONE_UP_MAX);
                default: begin
                    mode_roll = $urandom_range(99);
                    apply_settings(pick_level(20),
                                   {6'($urandom), (mode_roll < 80) ? 3'($urandom_range(0, 4))
                                                                   : 3'($urandom_range(5, 7))},
                                   pick_level(40), pick_tone(), pick_tone(), pick_tone());
                end
            endcase
            // writes to unused indexes must change nothing
            if (phase == 2) begin
                write_reg(CFG_UNUSED_6, 9'($urandom));
                write_reg(CFG_UNUSED_7, 9'($urandom));
            end
            full_rate = (phase % 6 == 4);
            burst = $urandom_range(50, 110);
            repeat (burst) begin
                if ($urandom_range(199) == 0) wait_idle();
                p = random_pixel();
                send_pixel(p, 1'b0, '0);
                pixels_sent++;
            end
            phase++;
        end
        full_rate = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("rgba_tone_and_blend_top regression: pass");
        else
            $display("rgba_tone_and_blend_top regression: fail");
        $finish;
    end

endmodule
